### rtl/core/hfm_pkg.sv
// Shared types, widths, register codes and the exponent table for the mask generator.
// No dependencies; every module of the core imports it.
package hfm_pkg;

    localparam int MAX_SIDE_N  = 4096;
    localparam int SIZE_W      = 13;
    localparam int POS_W       = 12;
    localparam int TENTHS_W    = 7;
    localparam int GAIN_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    localparam int SQ_W        = 2 * POS_W;
    localparam int DIST_W      = SQ_W + 1;
    localparam int NUM_W       = DIST_W + TENTHS_W;
    localparam int DEN_W       = 18;
    localparam int X_FRAC      = 16;
    localparam int X_W         = 21;
    localparam int N_W         = NUM_W + X_FRAC;
    localparam int HI_W        = N_W - X_W;
    localparam int DIV_STEP    = 3;
    localparam int DIV_STAGES  = X_W / DIV_STEP;
    localparam int ACC_W       = 33;
    localparam int FRAC_W      = 32;
    localparam int SUM_W       = FRAC_W + TENTHS_W + 1;
    localparam int T_W         = 20;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SH    = 23;
    localparam int SCALE_SH    = 20;

    localparam logic [SIZE_W-1:0]   MAX_SIDE  = SIZE_W'(MAX_SIDE_N);
    localparam logic [ACC_W-1:0]    ONE_Q32   = {1'b1, {FRAC_W{1'b0}}};
    localparam logic [RECIP_W-1:0]  RECIP_10  = RECIP_W'(838861);
    localparam logic [SUM_W-1:0]    ROUND_Q12 = SUM_W'(5 << SCALE_SH);

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GHIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GLOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEEP = 3'd5;

    localparam logic [SIZE_W-1:0]   RST_ROWS  = 13'd512;
    localparam logic [SIZE_W-1:0]   RST_COLS  = 13'd512;
    localparam logic [TENTHS_W-1:0] RST_GHIGH = 7'd20;
    localparam logic [TENTHS_W-1:0] RST_GLOW  = 7'd5;
    localparam logic [TENTHS_W-1:0] RST_CUT   = 7'd50;
    localparam logic [TENTHS_W-1:0] RST_STEEP = 7'd10;

    typedef struct packed {
        logic [SIZE_W-1:0]   rows;
        logic [SIZE_W-1:0]   cols;
        logic [TENTHS_W-1:0] gain_high;
        logic [TENTHS_W-1:0] gain_low;
        logic [TENTHS_W-1:0] cutoff;
        logic [TENTHS_W-1:0] steep;
    } cfg_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             dist_zero;
    } num_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [X_W-1:0]   low;
        logic [X_W-1:0]   quo;
        logic             vanish;
        logic             cut_zero;
    } div_t;

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [X_W-1:0]   x;
    } exp_t;

    // exp(-2^(i-16)) in Q0.32
    function automatic logic [FRAC_W-1:0] exp_bit(input logic [4:0] idx);
        logic [FRAC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'd4294901760;
            5'd1:    v = 32'd4294836226;
            5'd2:    v = 32'd4294705160;
            5'd3:    v = 32'd4294443040;
            5'd4:    v = 32'd4293918848;
            5'd5:    v = 32'd4292870656;
            5'd6:    v = 32'd4290774639;
            5'd7:    v = 32'd4286586875;
            5'd8:    v = 32'd4278222805;
            5'd9:    v = 32'd4261543595;
            5'd10:   v = 32'd4228380000;
            5'd11:   v = 32'd4162825044;
            5'd12:   v = 32'd4034748382;
            5'd13:   v = 32'd3790295335;
            5'd14:   v = 32'd3344923893;
            5'd15:   v = 32'd2605029347;
            5'd16:   v = 32'd1580030169;
            5'd17:   v = 32'd581260615;
            5'd18:   v = 32'd78665070;
            5'd19:   v = 32'd1440801;
            5'd20:   v = 32'd483;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/hfm_dist.sv
// Squared distance from the plane centre and the exponent numerator, four register stages.
// Depends on hfm_pkg.
module hfm_dist (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [hfm_pkg::POS_W-1:0]    row,
    input  logic [hfm_pkg::POS_W-1:0]    col,
    input  hfm_pkg::cfg_t                cfg,
    output logic                         out_valid,
    output hfm_pkg::num_t                out_word
);
    import hfm_pkg::*;

    logic [SIZE_W-1:0] rows_sat;
    logic [SIZE_W-1:0] cols_sat;
    logic [POS_W-1:0]  ctr_r;
    logic [POS_W-1:0]  ctr_c;
    logic [POS_W-1:0]  dr_next;
    logic [POS_W-1:0]  dc_next;

    logic              v1_reg, v2_reg, v3_reg, v4_reg;
    logic [POS_W-1:0]  dr_reg, dc_reg;
    logic [SQ_W-1:0]   sqr_reg, sqc_reg;
    logic [DIST_W-1:0] dist_reg;
    logic [DIST_W-1:0] dist_next;
    num_t              num_reg;

    always_comb
    begin
        rows_sat = (cfg.rows > MAX_SIDE) ? MAX_SIDE : cfg.rows;
        cols_sat = (cfg.cols > MAX_SIDE) ? MAX_SIDE : cfg.cols;
        ctr_r    = rows_sat[SIZE_W-1:1];
        ctr_c    = cols_sat[SIZE_W-1:1];
        dr_next  = (row >= ctr_r) ? (row - ctr_r) : (ctr_r - row);
        dc_next  = (col >= ctr_c) ? (col - ctr_c) : (ctr_c - col);
        dist_next = {1'b0, sqr_reg} + {1'b0, sqc_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dr_reg            <= dr_next;
        dc_reg            <= dc_next;
        sqr_reg           <= dr_reg * dr_reg;
        sqc_reg           <= dc_reg * dc_reg;
        dist_reg          <= dist_next;
        num_reg.num       <= NUM_W'(cfg.steep) * NUM_W'(dist_reg);
        num_reg.dist_zero <= (dist_reg == '0);
    end

    assign out_valid = v4_reg;
    assign out_word  = num_reg;

endmodule

### rtl/core/hfm_div.sv
// Pipelined restoring divider giving the Q16 exponent, three quotient bits per stage.
// Depends on hfm_pkg.
module hfm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  hfm_pkg::num_t                in_word,
    input  logic [hfm_pkg::DEN_W-1:0]    den,
    input  logic                         cut_zero,
    output logic                         out_valid,
    output logic [hfm_pkg::X_W-1:0]      x,
    output logic                         vanish
);
    import hfm_pkg::*;

    function automatic div_t div_step(input div_t d, input logic [DEN_W-1:0] dv);
        div_t           o;
        logic [DEN_W:0] r;
        o = d;
        for (int j = 0; j < DIV_STEP; j++)
        begin
            r     = {o.rem, o.low[X_W-1]};
            o.low = {o.low[X_W-2:0], 1'b0};
            if (r >= {1'b0, dv})
            begin
                r     = r - {1'b0, dv};
                o.quo = {o.quo[X_W-2:0], 1'b1};
            end
            else
            begin
                o.quo = {o.quo[X_W-2:0], 1'b0};
            end
            o.rem = r[DEN_W-1:0];
        end
        return o;
    endfunction

    logic [N_W-1:0]  n_full;
    logic [HI_W-1:0] n_hi;
    logic            sat;
    div_t            entry;

    logic            v_reg [0:DIV_STAGES];
    div_t            d_reg [0:DIV_STAGES];

    always_comb
    begin
        n_full         = {in_word.num, {X_FRAC{1'b0}}} + N_W'(den[DEN_W-1:1]);
        n_hi           = n_full[N_W-1:X_W];
        sat            = n_hi >= HI_W'(den);
        entry.rem      = n_hi[DEN_W-1:0];
        entry.low      = n_full[X_W-1:0];
        entry.quo      = '0;
        entry.cut_zero = cut_zero;
        entry.vanish   = cut_zero ? !in_word.dist_zero : sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg[0] <= entry;
    end

    for (genvar s = 1; s <= DIV_STAGES; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            d_reg[s] <= div_step(d_reg[s-1], den);
        end
    end

    assign out_valid = v_reg[DIV_STAGES];
    assign x         = d_reg[DIV_STAGES].cut_zero ? '0 : d_reg[DIV_STAGES].quo;
    assign vanish    = d_reg[DIV_STAGES].vanish;

endmodule

### rtl/core/hfm_exp.sv
// exp(-x) in Q1.32 as a chain of constant multiplies, one exponent bit per stage.
// Depends on hfm_pkg.
module hfm_exp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [hfm_pkg::X_W-1:0]      x,
    input  logic                         vanish,
    output logic                         out_valid,
    output logic [hfm_pkg::ACC_W-1:0]    e
);
    import hfm_pkg::*;

    function automatic exp_t exp_step(input exp_t s, input logic [4:0] idx);
        exp_t                o;
        logic [FRAC_W-1:0]   k;
        logic [2*FRAC_W-1:0] prod;
        o    = s;
        k    = exp_bit(idx);
        prod = ({{FRAC_W{1'b0}}, s.acc[FRAC_W-1:0]} * {{FRAC_W{1'b0}}, k})
               + (2*FRAC_W)'(ONE_Q32 >> 1);
        if (s.x[idx])
        begin
            if (s.acc[FRAC_W])
            begin
                o.acc = {1'b0, k};
            end
            else
            begin
                o.acc = {1'b0, prod[2*FRAC_W-1:FRAC_W]};
            end
        end
        return o;
    endfunction

    exp_t entry;
    logic v_reg [0:X_W-1];
    exp_t e_reg [0:X_W-1];

    always_comb
    begin
        entry.acc = vanish ? '0 : ONE_Q32;
        entry.x   = x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < X_W; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < X_W; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg[0] <= exp_step(entry, 5'd0);
    end

    for (genvar s = 1; s < X_W; s++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            e_reg[s] <= exp_step(e_reg[s-1], 5'(s));
        end
    end

    assign out_valid = v_reg[X_W-1];
    assign e         = e_reg[X_W-1].acc;

endmodule

### rtl/core/hfm_gain.sv
// Blend of low and high gain by the exponential term and scaling to Q4.12.
// Depends on hfm_pkg.
module hfm_gain (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [hfm_pkg::ACC_W-1:0]       e,
    input  logic [hfm_pkg::TENTHS_W-1:0]    gain_low,
    input  logic [hfm_pkg::TENTHS_W-1:0]    gain_high,
    output logic                            out_valid,
    output logic [hfm_pkg::GAIN_W-1:0]      gain
);
    import hfm_pkg::*;

    logic [ACC_W-1:0]         w;
    logic [SUM_W-1:0]         sum;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [SUM_W-1:0]         pl_reg, ph_reg;
    logic [T_W-1:0]           t_reg;
    logic [T_W+RECIP_W-1:0]   p_reg;
    logic [GAIN_W-1:0]        gain_reg;

    always_comb
    begin
        w   = ONE_Q32 - e;
        sum = pl_reg + ph_reg + ROUND_Q12;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pl_reg   <= SUM_W'(gain_low) * SUM_W'(e);
        ph_reg   <= SUM_W'(gain_high) * SUM_W'(w);
        t_reg    <= sum[SCALE_SH+T_W-1:SCALE_SH];
        p_reg    <= (T_W+RECIP_W)'(t_reg) * (T_W+RECIP_W)'(RECIP_10);
        gain_reg <= p_reg[RECIP_SH+GAIN_W-1:RECIP_SH];
    end

    assign out_valid = v4_reg;
    assign gain      = gain_reg;

endmodule

### rtl/core/homomorphic_filter_mask_gen_core.sv
// Top level of the homomorphic filter mask generator: configuration registers and pipeline.
// Depends on hfm_pkg, hfm_dist, hfm_div, hfm_exp and hfm_gain.
//
// Usage
//   Input: drive row and col with start high; the word is taken at each rising edge
//   where start is high and busy is low. busy stays low, so a new point may enter
//   on every cycle.
//   Output: done is high for one cycle with the Q4.12 gain on gain. Words leave
//   in the order they entered. Throughput is one gain per cycle; the pipeline
//   holds the distance stages, the 8-stage divider that forms the exponent,
//   the 21-stage exponent multiply chain and the gain stages.
//   The receiver has no way to hold results off; every word must be taken.
//   Configuration: cfg_valid with cfg_index and cfg_data writes one register;
//   cfg_ready is always high. Write only while no point is in flight.
//   Unknown indexes are dropped.
//   Reset: rst_n low clears the pipeline and loads the default plane size,
//   gains, cutoff and steepness. No clearing pass follows.
module homomorphic_filter_mask_gen_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hfm_pkg::POS_W-1:0]       row,
    input  logic [hfm_pkg::POS_W-1:0]       col,
    output logic                            done,
    output logic [hfm_pkg::GAIN_W-1:0]      gain,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import hfm_pkg::*;

    cfg_t               cfg_reg;
    cfg_t               cfg_next;
    logic [DEN_W-1:0]   den_reg;
    logic               accept;

    logic               dist_valid;
    num_t               dist_word;
    logic               div_valid;
    logic [X_W-1:0]     div_x;
    logic               div_vanish;
    logic               exp_valid;
    logic [ACC_W-1:0]   exp_e;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROWS:  cfg_next.rows      = cfg_data;
                REG_COLS:  cfg_next.cols      = cfg_data;
                REG_GHIGH: cfg_next.gain_high = cfg_data[TENTHS_W-1:0];
                REG_GLOW:  cfg_next.gain_low  = cfg_data[TENTHS_W-1:0];
                REG_CUT:   cfg_next.cutoff    = cfg_data[TENTHS_W-1:0];
                REG_STEEP: cfg_next.steep     = cfg_data[TENTHS_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows      <= RST_ROWS;
            cfg_reg.cols      <= RST_COLS;
            cfg_reg.gain_high <= RST_GHIGH;
            cfg_reg.gain_low  <= RST_GLOW;
            cfg_reg.cutoff    <= RST_CUT;
            cfg_reg.steep     <= RST_STEEP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // hold 10 * cutoff^2 for the divider
    always_ff @(posedge clk)
    begin
        den_reg <= DEN_W'(cfg_reg.cutoff) * DEN_W'(cfg_reg.cutoff) * DEN_W'(10);
    end

    hfm_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .row       (row),
        .col       (col),
        .cfg       (cfg_reg),
        .out_valid (dist_valid),
        .out_word  (dist_word)
    );

    hfm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dist_valid),
        .in_word   (dist_word),
        .den       (den_reg),
        .cut_zero  (cfg_reg.cutoff == '0),
        .out_valid (div_valid),
        .x         (div_x),
        .vanish    (div_vanish)
    );

    hfm_exp u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .x         (div_x),
        .vanish    (div_vanish),
        .out_valid (exp_valid),
        .e         (exp_e)
    );

    hfm_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (exp_valid),
        .e         (exp_e),
        .gain_low  (cfg_reg.gain_low),
        .gain_high (cfg_reg.gain_high),
        .out_valid (done),
        .gain      (gain)
    );

endmodule
